@@ hdl/mts_pkg.sv @@
`default_nettype none

package mts_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DATA_W      = 32;
    localparam int WORD_W      = DATA_W + 2;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int STATUS_W    = 2;
    localparam int RES_W       = 3 * DATA_W + 1 + STATUS_W;
    localparam int OUT_W       = ((RES_W + 7) / 8) * 8;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 2'd0,
        STAT_POP_EMPTY  = 2'd1,
        STAT_PUSH_FULL  = 2'd2
    } status_t;

endpackage

`default_nettype wire

@@ hdl/mts_stack_ram.sv @@
`default_nettype none

module mts_stack_ram (
    input  wire logic                           aclk,
    input  wire logic                           wr_en,
    input  wire logic [mts_pkg::ADDR_W-1:0]     wr_addr,
    input  wire logic [mts_pkg::WORD_W-1:0]     wr_data,
    input  wire logic [mts_pkg::ADDR_W-1:0]     rd_addr,
    output logic      [mts_pkg::WORD_W-1:0]     rd_data
);

    logic [mts_pkg::WORD_W-1:0] mem [mts_pkg::STACK_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ hdl/min_tracking_stack_unit.sv @@
// An accepted item waits in S_EXEC until the result register is free or being taken;
// its result is then registered. A new item is taken only in S_IDLE, and S_EXEC covers the
// registered read of the stack-memory entry below the top, which a pop needs for the new top.
// The word on top of the stack is also held in a register, so a push needs no read.
// Reset (aresetn, synchronous, active low) empties the stack, zeroes the minimum and
// drops any pending result; the stack memory itself is not cleared.
`default_nettype none

module min_tracking_stack_unit (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [mts_pkg::DATA_W-1:0]  s_tdata,   // [31:0] value
    input  wire logic                        s_tuser,   // [0] command
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // [31:0] popped_value, [63:32] top_value, [95:64] min_value, [96] is_empty,
    // [98:97] status, upper bits zero
    output logic      [mts_pkg::OUT_W-1:0]   m_tdata
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                         state_reg, state_next;
    mts_pkg::cmd_t                  cmd_reg, cmd_next;
    logic signed [mts_pkg::DATA_W-1:0] val_reg, val_next;
    logic [mts_pkg::CNT_W-1:0]      count_reg, count_next;
    logic signed [mts_pkg::DATA_W-1:0] min_reg, min_next;
    logic signed [mts_pkg::WORD_W-1:0] top_word_reg, top_word_next;

    logic                           m_tvalid_reg, m_tvalid_next;
    logic [mts_pkg::DATA_W-1:0]     popped_reg, popped_next;
    logic [mts_pkg::DATA_W-1:0]     top_reg, top_next;
    logic [mts_pkg::DATA_W-1:0]     minout_reg, minout_next;
    logic                           empty_reg, empty_next;
    mts_pkg::status_t               status_reg, status_next;

    logic                           accept;
    logic                           exec_go;
    logic [mts_pkg::CNT_W-1:0]      cnt_m2;
    logic [mts_pkg::ADDR_W-1:0]     rd_addr;
    logic signed [mts_pkg::WORD_W-1:0] rd_data;
    logic                           wr_en;
    logic signed [mts_pkg::WORD_W-1:0] wr_data;

    logic signed [mts_pkg::WORD_W-1:0] x_ext;
    logic signed [mts_pkg::WORD_W-1:0] min_ext;
    logic signed [mts_pkg::WORD_W-1:0] push_enc;
    logic signed [mts_pkg::WORD_W-1:0] restored;
    logic signed [mts_pkg::DATA_W-1:0] new_min;
    logic signed [mts_pkg::WORD_W-1:0] new_min_ext;
    logic [mts_pkg::DATA_W-1:0]     cur_top;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign exec_go  = (state_reg == S_EXEC) && (!m_tvalid_reg || m_tready);

    // The entry below the current top; it only matters when a pop leaves the stack non-empty.
    assign cnt_m2  = count_reg - mts_pkg::CNT_W'(2);
    assign rd_addr = cnt_m2[mts_pkg::ADDR_W-1:0];

    mts_stack_ram u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[mts_pkg::ADDR_W-1:0]),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign x_ext    = mts_pkg::WORD_W'(val_reg);
    assign min_ext  = mts_pkg::WORD_W'(min_reg);
    assign push_enc = (x_ext <<< 1) - min_ext;
    assign restored = (min_ext <<< 1) - top_word_reg;
    assign cur_top  = (top_word_reg >= min_ext) ? top_word_reg[mts_pkg::DATA_W-1:0]
                                                : min_reg;

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        val_next      = val_reg;
        count_next    = count_reg;
        min_next      = min_reg;
        top_word_next = top_word_reg;
        popped_next   = popped_reg;
        top_next      = top_reg;
        minout_next   = minout_reg;
        empty_next    = empty_reg;
        status_next   = status_reg;
        wr_en         = 1'b0;
        wr_data       = x_ext;
        new_min       = min_reg;
        new_min_ext   = min_ext;

        m_tvalid_next = exec_go ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

        if (accept) begin
            cmd_next   = mts_pkg::cmd_t'(s_tuser);
            val_next   = s_tdata;
            state_next = S_EXEC;
        end

        if (exec_go) begin
            state_next  = S_IDLE;
            status_next = mts_pkg::STAT_OK;
            popped_next = '0;
            unique case (cmd_reg)
                mts_pkg::CMD_PUSH: begin
                    if (count_reg == mts_pkg::CNT_W'(mts_pkg::STACK_DEPTH)) begin
                        status_next = mts_pkg::STAT_PUSH_FULL;
                        top_next    = cur_top;
                        minout_next = min_reg;
                        empty_next  = 1'b0;
                    end else begin
                        wr_en = 1'b1;
                        // A value below the minimum is stored encoded so that the old
                        // minimum can be recovered when it is popped.
                        if (count_reg != '0 && val_reg < min_reg) begin
                            wr_data = push_enc;
                        end
                        if (count_reg == '0 || val_reg < min_reg) begin
                            min_next = val_reg;
                        end
                        top_word_next = wr_data;
                        count_next    = count_reg + mts_pkg::CNT_W'(1);
                        top_next      = val_reg;
                        minout_next   = (count_reg == '0 || val_reg < min_reg) ? val_reg
                                                                                : min_reg;
                        empty_next    = 1'b0;
                    end
                end
                mts_pkg::CMD_POP: begin
                    if (count_reg == '0) begin
                        status_next = mts_pkg::STAT_POP_EMPTY;
                        popped_next = '1;
                        top_next    = '1;
                        minout_next = '1;
                        empty_next  = 1'b1;
                    end else begin
                        if (top_word_reg < min_ext) begin
                            popped_next = min_reg;
                            new_min     = restored[mts_pkg::DATA_W-1:0];
                        end else begin
                            popped_next = top_word_reg[mts_pkg::DATA_W-1:0];
                        end
                        new_min_ext   = mts_pkg::WORD_W'(new_min);
                        min_next      = new_min;
                        count_next    = count_reg - mts_pkg::CNT_W'(1);
                        top_word_next = rd_data;
                        if (count_reg == mts_pkg::CNT_W'(1)) begin
                            top_next    = '1;
                            minout_next = '1;
                            empty_next  = 1'b1;
                        end else begin
                            top_next    = (rd_data >= new_min_ext)
                                          ? rd_data[mts_pkg::DATA_W-1:0] : new_min;
                            minout_next = new_min;
                            empty_next  = 1'b0;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        cmd_next_hold: begin
            cmd_reg      <= cmd_next;
            val_reg      <= val_next;
            top_word_reg <= top_word_next;
            popped_reg   <= popped_next;
            top_reg      <= top_next;
            minout_reg   <= minout_next;
            empty_reg    <= empty_next;
            status_reg   <= status_next;
        end
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            min_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            min_reg      <= min_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = mts_pkg::OUT_W'({status_reg, empty_reg, minout_reg, top_reg,
                                       popped_reg});

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= mts_pkg::CNT_W'(mts_pkg::STACK_DEPTH))
        else $error("stack count exceeds depth");

    a_one_item_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("second transaction accepted while an item is in flight");

    a_count_moves_on_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != count_next) |-> exec_go)
        else $error("stack count changed outside execution");

    a_pop_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && status_reg == mts_pkg::STAT_POP_EMPTY) |-> empty_reg)
        else $error("pop on empty stack reported a non-empty stack");

    a_write_below_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (count_reg < mts_pkg::CNT_W'(mts_pkg::STACK_DEPTH)))
        else $error("write into a full stack");

endmodule

`default_nettype wire

@@ bench/mts_checker.sv @@
module mts_checker (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    input  wire logic                        s_tready,
    input  wire logic [mts_pkg::DATA_W-1:0]  s_tdata,   // [31:0] value
    input  wire logic                        s_tuser,   // [0] command
    input  wire logic                        m_tvalid,
    input  wire logic                        m_tready,
    // [31:0] popped_value, [63:32] top_value, [95:64] min_value, [96] is_empty,
    // [98:97] status, upper bits zero
    input  wire logic [mts_pkg::OUT_W-1:0]   m_tdata,
    output int                               error_count,
    output int                               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import mts_pkg::*;

    typedef struct {
        logic [DATA_W-1:0] popped;
        logic [DATA_W-1:0] top;
        logic [DATA_W-1:0] minv;
        logic              empty;
        status_t           status;
    } stack_result_t;

    // Shadow copy of the stack, holding the same encoded words as the block.
    logic signed [WORD_W-1:0] words [STACK_DEPTH];
    int unsigned              depth_used;
    logic signed [DATA_W-1:0] run_min;
    stack_result_t            expected_q[$];

    initial begin
        error_count = 0;
        pending     = 0;
        depth_used  = 0;
        run_min     = '0;
    end

    function automatic stack_result_t apply_op(cmd_t cmd, logic signed [DATA_W-1:0] x);
        stack_result_t r;
        longint        w;
        longint        m;
        r.popped = '0;
        r.status = STAT_OK;
        m = run_min;
        if (cmd == CMD_PUSH) begin
            if (depth_used >= STACK_DEPTH) begin
                r.status = STAT_PUSH_FULL;
            end else if (depth_used == 0) begin
                words[0]   = x;
                run_min    = x;
                depth_used = 1;
            end else if (x >= run_min) begin
                words[depth_used] = x;
                depth_used++;
            end else begin
                // A new minimum is stored as an encoded word, so the old one can be rebuilt.
                w = 2 * longint'(x) - m;
                words[depth_used] = w[WORD_W-1:0];
                run_min = x;
                depth_used++;
            end
        end else begin
            if (depth_used == 0) begin
                r.popped = '1;
                r.status = STAT_POP_EMPTY;
            end else begin
                w = words[depth_used-1];
                depth_used--;
                if (w < m) begin
                    r.popped = run_min;
                    m        = 2 * m - w;
                    run_min  = m[DATA_W-1:0];
                end else begin
                    r.popped = w[DATA_W-1:0];
                end
            end
        end
        if (depth_used == 0) begin
            r.top   = '1;
            r.minv  = '1;
            r.empty = 1'b1;
        end else begin
            w = words[depth_used-1];
            m = run_min;
            if (w >= m) begin
                r.top = w[DATA_W-1:0];
            end else begin
                r.top = run_min;
            end
            r.minv  = run_min;
            r.empty = 1'b0;
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        stack_result_t want;
        if (!aresetn) begin
            expected_q.delete();
            depth_used = 0;
            run_min    = '0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_q.push_back(apply_op(cmd_t'(s_tuser), s_tdata));
            end
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    $error("result transaction with no operation waiting");
                    error_count++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("popped_value", want.popped, m_tdata[31:0]);
                    check_field("top_value", want.top, m_tdata[63:32]);
                    check_field("min_value", want.minv, m_tdata[95:64]);
                    check_field("is_empty", want.empty, m_tdata[96]);
                    check_field("status", want.status, m_tdata[98:97]);
                end
            end
        end
        pending <= expected_q.size();
    end

endmodule

@@ bench/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mts_pkg::*;

    localparam int TOTAL_OPS   = 1500;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 200;
    localparam int QUIET_FROM  = 900;
    localparam int QUIET_TO    = 1100;
    localparam int DRAIN_AT    = 700;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic [DATA_W-1:0] INT_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] INT_MAX = 32'h7FFF_FFFF;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata  = '0;
    logic              s_tuser  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;

    int error_count;
    int pending;
    int ops_sent    = 0;
    int cycle_count = 0;
    int hold_left   = 0;
    bit hold_done   = 0;
    bit quiet       = 0;

    min_tracking_stack_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    mts_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .error_count (error_count),
        .pending     (pending)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Result side: random back-pressure, one long hold-off, and a stretch that never stalls.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (!hold_done && ops_sent >= HOLD_AT) begin
            hold_done = 1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (quiet) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= 8);
        end
    end

    // Called at a rising edge; returns at the edge where the transaction completed, or after a random idle gap.
    task automatic push_op(cmd_t cmd, logic [DATA_W-1:0] value);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        ops_sent++;
        quiet = (ops_sent >= QUIET_FROM) && (ops_sent < QUIET_TO);
        if (!quiet && $urandom_range(0, 99) < 8) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5, 6:    v = $urandom_range(0, 16) - 8;
            7:          v = INT_MIN;
            8:          v = INT_MAX;
            default:    v = $urandom_range(0, 1) ? '1 : '0;
        endcase
        return v;
    endfunction

    initial begin
        int   burst_len;
        int   push_pct;
        bit   drained_mid;
        cmd_t cmd;
        drained_mid = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty pops, equal minima, both extremes, and the widest encoded word.
        push_op(CMD_POP, '0);
        push_op(CMD_PUSH, 32'd5);
        push_op(CMD_PUSH, 32'd5);
        push_op(CMD_PUSH, 32'd7);
        push_op(CMD_PUSH, 32'd3);
        push_op(CMD_PUSH, INT_MIN);
        push_op(CMD_PUSH, INT_MIN);
        push_op(CMD_PUSH, INT_MAX);
        repeat (7) push_op(CMD_POP, '1);
        push_op(CMD_POP, 32'h1234_5678);
        push_op(CMD_PUSH, INT_MAX);
        push_op(CMD_PUSH, INT_MIN);
        push_op(CMD_PUSH, '1);
        repeat (3) push_op(CMD_POP, '0);
        push_op(CMD_PUSH, '0);
        push_op(CMD_PUSH, '1);
        repeat (2) push_op(CMD_POP, '0);
        wait_results_done();

        // Random bursts with a changing push share, so the stack sweeps between empty and full.
        burst_len = 100;
        push_pct  = 90;
        while (ops_sent < TOTAL_OPS) begin
            repeat (burst_len) begin
                cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
                push_op(cmd, pick_value());
            end
            if (!drained_mid && ops_sent >= DRAIN_AT) begin
                drained_mid = 1;
                wait_results_done();
            end
            burst_len = $urandom_range(20, 120);
            case ($urandom_range(0, 2))
                0:       push_pct = 85;
                1:       push_pct = 50;
                default: push_pct = 15;
            endcase
        end

        wait_results_done();
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
